>>> design/glmr_pkg.sv
// Shared types, constants and the neighbor compare for the local minimum risk block.
package glmr_pkg;

    localparam int CFG_BITS       = 8;
    localparam int HEIGHT_BITS    = 4;
    localparam int RISK_BITS      = 4;
    localparam int COL_BITS       = 7;
    localparam int RESET_WIDTH    = 128;
    localparam int MAX_WIDTH_DEF  = 128;
    localparam int TOTAL_BITS_DEF = 24;
    localparam int QUEUE_DEPTH    = 4;
    localparam int IN_DW          = 8;

    // result slots of one input, in emission order
    localparam int NSLOT      = 3;
    localparam int SLOT_ABOVE = 0;
    localparam int SLOT_LEFT  = 1;
    localparam int SLOT_FINAL = 2;

    localparam logic [RISK_BITS-1:0] RISK_MAX = '1;

    typedef logic [HEIGHT_BITS-1:0] height_t;

    typedef struct packed {
        logic [RISK_BITS-1:0] risk;
        logic [COL_BITS-1:0]  column;
    } res_t;

    typedef struct packed {
        logic [NSLOT-1:0] vld;
        res_t [NSLOT-1:0] res;
    } qent_t;

    // Zero unless every present neighbor is strictly higher; else height+1, saturating.
    function automatic logic [RISK_BITS-1:0] cell_risk(
        input height_t center,
        input height_t l, input logic l_ok,
        input height_t r, input logic r_ok,
        input height_t u, input logic u_ok,
        input height_t d, input logic d_ok
    );
        logic blocked;
        blocked = (l_ok && (l <= center)) || (r_ok && (r <= center)) ||
                  (u_ok && (u <= center)) || (d_ok && (d <= center));
        if (blocked)
        begin
            return '0;
        end
        else if (center == RISK_MAX)
        begin
            return RISK_MAX;
        end
        else
        begin
            return RISK_BITS'(center) + RISK_BITS'(1);
        end
    endfunction

endpackage

>>> design/glmr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module glmr_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> design/glmr_fifo.sv
// Short show-ahead queue between the classifier front and the result back end.
module glmr_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty,
    output logic             full
);

    localparam int PW = $clog2(DEPTH);
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CNTW-1:0]  count_reg;

    assign rdata = mem_reg[rd_ptr_reg];
    assign empty = (count_reg == '0);
    assign full  = (count_reg == CNTW'(DEPTH));

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CNTW'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CNTW'(1);
            end
        end
    end

endmodule

>>> design/glmr_front.sv
// Front end: row buffers, neighbor prefetch and classification of each accepted cell.
module glmr_front
    import glmr_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [CFG_BITS-1:0] cfg_wdata,
    input  logic                accept,
    input  height_t             height,
    input  logic                last_row,
    output logic                push,
    output qent_t               entry
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WIDE = (CW + 1 > CFG_BITS) ? CW + 1 : CFG_BITS;
    localparam int RESET_CLAMP = (RESET_WIDTH < MAX_WIDTH) ? RESET_WIDTH : MAX_WIDTH;
    localparam logic [CW-1:0] RESET_LAST = CW'(RESET_CLAMP - 1);

    logic [CW-1:0] last_col_reg, last_col_next;
    logic [CW-1:0] col_reg;
    logic [1:0]    rows_reg;
    height_t       left_reg, pend_reg, h2_reg, above_reg;
    logic          pfp_fwd_reg;
    height_t       pfp_val_reg;
    logic          ofwd_reg;
    height_t       oval_reg;

    height_t       prior_dout, older_dout;
    height_t       prior_rd, above, u_val;
    logic [CW-1:0] pa, oa;
    logic [CW:0]   s2, w_ext;
    logic [WIDE-1:0] wd;
    logic          first_col, col_is_last, col_ge2, rows_ge1, rows_ge2, final_in;

    // prior row: read two columns ahead; older row: read one column ahead
    glmr_ram #(.WIDTH(HEIGHT_BITS), .DEPTH(MAX_WIDTH)) u_prior (
        .clk   (clk),
        .we    (accept),
        .waddr (col_reg),
        .wdata (height),
        .re    (accept),
        .raddr (pa),
        .rdata (prior_dout)
    );

    glmr_ram #(.WIDTH(HEIGHT_BITS), .DEPTH(MAX_WIDTH)) u_older (
        .clk   (clk),
        .we    (accept),
        .waddr (col_reg),
        .wdata (above),
        .re    (accept),
        .raddr (oa),
        .rdata (older_dout)
    );

    always_comb
    begin
        wd = WIDE'(cfg_wdata);
        if (wd == '0)
        begin
            last_col_next = '0;
        end
        else if (wd > WIDE'(MAX_WIDTH))
        begin
            last_col_next = CW'(MAX_WIDTH - 1);
        end
        else
        begin
            last_col_next = CW'(wd - WIDE'(1));
        end
    end

    assign first_col   = (col_reg == '0);
    assign col_is_last = (col_reg == last_col_reg);
    assign col_ge2     = ({1'b0, col_reg} >= (CW + 1)'(2));
    assign rows_ge1    = (rows_reg != '0);
    assign rows_ge2    = rows_reg[1];
    assign final_in    = last_row && col_is_last;

    // a read that lands on the column written now takes the written value
    assign prior_rd = pfp_fwd_reg ? pfp_val_reg : prior_dout;
    assign above    = (last_col_reg == '0) ? prior_rd : above_reg;
    assign u_val    = ofwd_reg ? oval_reg : older_dout;

    always_comb
    begin
        s2    = {1'b0, col_reg} + (CW + 1)'(2);
        w_ext = {1'b0, last_col_reg} + (CW + 1)'(1);
        if (last_col_reg == '0)
        begin
            pa = '0;
        end
        else if (s2 > {1'b0, last_col_reg})
        begin
            pa = CW'(s2 - w_ext);
        end
        else
        begin
            pa = CW'(s2);
        end
        oa = col_is_last ? '0 : col_reg + CW'(1);
    end

    always_comb
    begin
        entry = '0;
        entry.vld[SLOT_ABOVE]        = rows_ge1;
        entry.res[SLOT_ABOVE].risk   = cell_risk(above, left_reg, !first_col,
                                                 prior_rd, !col_is_last,
                                                 u_val, rows_ge2, height, 1'b1);
        entry.res[SLOT_ABOVE].column = COL_BITS'(col_reg);

        entry.vld[SLOT_LEFT]         = last_row && !first_col;
        entry.res[SLOT_LEFT].risk    = cell_risk(pend_reg, h2_reg, col_ge2,
                                                 height, 1'b1, left_reg, rows_ge1,
                                                 '0, 1'b0);
        entry.res[SLOT_LEFT].column  = COL_BITS'(col_reg - CW'(1));

        entry.vld[SLOT_FINAL]        = final_in;
        entry.res[SLOT_FINAL].risk   = cell_risk(height, pend_reg, !first_col,
                                                 '0, 1'b0, above, rows_ge1, '0, 1'b0);
        entry.res[SLOT_FINAL].column = COL_BITS'(col_reg);
    end

    assign push = accept && (entry.vld != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_col_reg <= RESET_LAST;
            col_reg      <= '0;
            rows_reg     <= '0;
            pfp_fwd_reg  <= 1'b0;
            ofwd_reg     <= 1'b0;
        end
        else if (cfg_we)
        begin
            last_col_reg <= last_col_next;
            col_reg      <= '0;
            rows_reg     <= '0;
        end
        else if (accept)
        begin
            pfp_fwd_reg <= (pa == col_reg);
            ofwd_reg    <= (oa == col_reg);
            if (final_in)
            begin
                col_reg  <= '0;
                rows_reg <= '0;
            end
            else if (col_is_last)
            begin
                col_reg <= '0;
                if (!rows_ge2)
                begin
                    rows_reg <= rows_reg + 2'd1;
                end
            end
            else
            begin
                col_reg <= col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            left_reg    <= above;
            pend_reg    <= height;
            h2_reg      <= pend_reg;
            above_reg   <= prior_rd;
            pfp_val_reg <= height;
            oval_reg    <= above;
        end
    end

endmodule

>>> design/glmr_back.sv
// Back end: drains queued result slots one beat at a time and keeps the risk total.
module glmr_back
    import glmr_pkg::*;
#(
    parameter int TOTAL_BITS = TOTAL_BITS_DEF
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       cfg_we,
    input  qent_t                                      head,
    input  logic                                       head_valid,
    output logic                                       pop,
    output logic                                       m_tvalid,
    input  logic                                       m_tready,
    output logic [((RISK_BITS+COL_BITS+TOTAL_BITS+7)/8)*8-1:0] m_tdata,
    output logic                                       m_tuser,
    output logic                                       m_tlast
);

    localparam int OUT_DW = ((RISK_BITS + COL_BITS + TOTAL_BITS + 7) / 8) * 8;

    logic [NSLOT-1:0]      done_reg;
    logic [TOTAL_BITS-1:0] total_reg;
    logic                  m_tvalid_reg;
    logic [RISK_BITS-1:0]  risk_reg;
    logic [COL_BITS-1:0]   col_reg;
    logic [TOTAL_BITS-1:0] tot_out_reg;
    logic                  end_reg;
    logic                  last_reg;

    logic [NSLOT-1:0]      rem, pick, after;
    logic [RISK_BITS-1:0]  sel_risk;
    logic [COL_BITS-1:0]   sel_col;
    logic [TOTAL_BITS:0]   sum;
    logic [TOTAL_BITS-1:0] new_total;
    logic                  out_ld, is_last;

    assign rem     = head.vld & ~done_reg;
    assign pick    = rem & (~rem + NSLOT'(1));
    assign after   = rem & ~pick;
    assign is_last = (after == '0);
    assign out_ld  = head_valid && (!m_tvalid_reg || m_tready);
    assign pop     = out_ld && is_last;

    always_comb
    begin
        sel_risk = '0;
        sel_col  = '0;
        for (int i = 0; i < NSLOT; i++)
        begin
            if (pick[i])
            begin
                sel_risk = sel_risk | head.res[i].risk;
                sel_col  = sel_col | head.res[i].column;
            end
        end
        sum       = {1'b0, total_reg} + (TOTAL_BITS + 1)'(sel_risk);
        new_total = sum[TOTAL_BITS] ? '1 : sum[TOTAL_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg     <= '0;
            total_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (out_ld)
            begin
                m_tvalid_reg <= 1'b1;
                done_reg     <= is_last ? '0 : (done_reg | pick);
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end

            // the grid-end beat closes the grid and restarts the total; a config write also restarts it
            if (cfg_we || (out_ld && pick[SLOT_FINAL]))
            begin
                total_reg <= '0;
            end
            else if (out_ld)
            begin
                total_reg <= new_total;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ld)
        begin
            risk_reg    <= sel_risk;
            col_reg     <= sel_col;
            tot_out_reg <= new_total;
            end_reg     <= pick[SLOT_FINAL];
            last_reg    <= is_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_DW'({tot_out_reg, col_reg, risk_reg});
    assign m_tuser  = end_reg;
    assign m_tlast  = last_reg;

endmodule

>>> design/grid_local_minimum_risk.sv
// Top level of the streaming 4-neighbor local minimum risk detector.
//
// Input stream (s_*): one grid cell per beat in raster order; s_tdata[3:0] carries
// the height, s_tuser flags a cell of the grid's final row. Output stream (m_*):
// one result per beat with risk, column and running risk total in m_tdata,
// end_of_grid in m_tuser and last_of_run in m_tlast.
// A cell's result leaves once the cell below it arrives; in the final row a cell
// leaves when its right neighbor arrives, and the grid's last cell flushes itself.
// Configuration: cfg_we with cfg_wdata writes the row width (0 reads as 1, larger
// than MAX_WIDTH reads as MAX_WIDTH) and restarts the grid; write only while idle.
// The first result of a beat passes the queue and then the output register before
// it appears on m_tvalid; further results of the same beat follow one per cycle
// while m_tready holds. Throughput: one cell per cycle while each cell yields at
// most one result and m_tready holds. A final-row cell yields up to three results
// and the single output port sends one per cycle, so the last row runs slower.
// A four-entry queue between the classifier and the output stage absorbs bursts;
// s_tready drops only when that queue is full, so a stalled receiver backs up
// through the output register and queue before the input stalls.
// Reset: control state clears at once; row buffers need no clearing pass since
// every column is written in a row before the next row reads it.
module grid_local_minimum_risk
    import glmr_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int TOTAL_BITS = TOTAL_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [CFG_BITS-1:0] cfg_wdata,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [IN_DW-1:0]    s_tdata,   // [3:0] height
    input  logic                s_tuser,   // last_row
    output logic                m_tvalid,
    input  logic                m_tready,
    // [3:0] risk, [10:4] column, [TOTAL_BITS+10:11] risk_total
    output logic [((RISK_BITS+COL_BITS+TOTAL_BITS+7)/8)*8-1:0] m_tdata,
    output logic                m_tuser,   // end_of_grid
    output logic                m_tlast    // last_of_run
);

    logic  accept;
    logic  q_push, q_pop, q_empty, q_full;
    qent_t q_wentry, q_head;
    logic [$bits(qent_t)-1:0] q_rdata;

    // hold the input only while the queue has no free entry
    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    glmr_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .accept    (accept),
        .height    (s_tdata[HEIGHT_BITS-1:0]),
        .last_row  (s_tuser),
        .push      (q_push),
        .entry     (q_wentry)
    );

    glmr_fifo #(.WIDTH($bits(qent_t)), .DEPTH(QUEUE_DEPTH)) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wentry),
        .pop   (q_pop),
        .rdata (q_rdata),
        .empty (q_empty),
        .full  (q_full)
    );

    assign q_head = qent_t'(q_rdata);

    glmr_back #(.TOTAL_BITS(TOTAL_BITS)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .head       (q_head),
        .head_valid (!q_empty),
        .pop        (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

`ifndef SYNTH
    // never write a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("queue written while full");

    // never drain an empty queue
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("queue popped while empty");

    // the grid-end result always closes its run
    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> m_tlast)
        else $error("end of grid without last of run");
`endif

endmodule
